// File: design/rrl_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and defaults of the IP range region lookup.
package rrl_pkg;

  // Default table geometry
  localparam int MAX_ENTRIES_DEF = 4096;
  localparam int BLOCK_SIZE_DEF  = 256;

  // Operation codes carried in func
  localparam logic [1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [1:0] FUNC_APPEND = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // One stored range
  typedef struct packed {
    logic [31:0] first;
    logic [31:0] last;
    logic [31:0] region;
  } entry_t;

  // One coarse index span
  typedef struct packed {
    logic [31:0] first;
    logic [31:0] last;
  } span_t;

  // One result word
  typedef struct packed {
    logic [31:0] region_code;
    logic        hit;
    logic        status;
  } result_t;

endpackage

// File: design/rrl_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and result words.

interface rrl_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] range_begin;
  logic [31:0] range_end;
  logic [31:0] range_region;
  logic [31:0] query_address;

  modport source (
    output valid, func, range_begin, range_end, range_region, query_address,
    input  ready
  );
  modport sink (
    input  valid, func, range_begin, range_end, range_region, query_address,
    output ready
  );
endinterface

interface rrl_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] region_code;
  logic        hit;
  logic        status;

  modport source (
    output valid, region_code, hit, status,
    input  ready
  );
  modport sink (
    input  valid, region_code, hit, status,
    output ready
  );
endinterface

// File: design/rrl_store.sv
`timescale 1ns / 1ps
// Range entry memory and coarse index memory, both with registered reads.
module rrl_store #(
  parameter int MAX_ENTRIES = rrl_pkg::MAX_ENTRIES_DEF,
  parameter int BLOCK_SIZE  = rrl_pkg::BLOCK_SIZE_DEF,
  localparam int ADDR_W     = $clog2(MAX_ENTRIES),
  localparam int NUM_BLOCKS = (MAX_ENTRIES + BLOCK_SIZE - 1) / BLOCK_SIZE,
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                 clk,
  // entry port
  input  logic                 ent_we,
  input  logic [ADDR_W-1:0]    ent_waddr,
  input  rrl_pkg::entry_t      ent_wdata,
  input  logic                 ent_re,
  input  logic [ADDR_W-1:0]    ent_raddr,
  output rrl_pkg::entry_t      ent_rdata,
  // index port
  input  logic                 idx_we_first,
  input  logic                 idx_we_last,
  input  logic [BLK_W-1:0]     idx_waddr,
  input  rrl_pkg::span_t       idx_wdata,
  input  logic                 idx_re,
  input  logic [BLK_W-1:0]     idx_raddr,
  output rrl_pkg::span_t       idx_rdata
);
  import rrl_pkg::*;

  entry_t      ent_mem [MAX_ENTRIES];
  logic [31:0] idx_first_mem [NUM_BLOCKS];
  logic [31:0] idx_last_mem  [NUM_BLOCKS];

  // Entry memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    if (ent_re) begin
      ent_rdata <= ent_mem[ent_raddr];
    end
  end

  // Index memory: span begin and span end lanes
  always_ff @(posedge clk) begin
    if (idx_we_first) begin
      idx_first_mem[idx_waddr] <= idx_wdata.first;
    end
    if (idx_we_last) begin
      idx_last_mem[idx_waddr] <= idx_wdata.last;
    end
    if (idx_re) begin
      idx_rdata.first <= idx_first_mem[idx_raddr];
      idx_rdata.last  <= idx_last_mem[idx_raddr];
    end
  end

endmodule

// File: design/rrl_ctrl.sv
`timescale 1ns / 1ps
// Sequencer: appends, clears and the two-level binary search over the memories.
module rrl_ctrl #(
  parameter int MAX_ENTRIES = rrl_pkg::MAX_ENTRIES_DEF,
  parameter int BLOCK_SIZE  = rrl_pkg::BLOCK_SIZE_DEF,
  localparam int ADDR_W     = $clog2(MAX_ENTRIES),
  localparam int NUM_BLOCKS = (MAX_ENTRIES + BLOCK_SIZE - 1) / BLOCK_SIZE,
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  rrl_in_if.sink               in_chan,
  output logic                 res_valid,
  input  logic                 res_ready,
  output rrl_pkg::result_t     res,
  // entry memory
  output logic                 ent_we,
  output logic [ADDR_W-1:0]    ent_waddr,
  output rrl_pkg::entry_t      ent_wdata,
  output logic                 ent_re,
  output logic [ADDR_W-1:0]    ent_raddr,
  input  rrl_pkg::entry_t      ent_rdata,
  // index memory
  output logic                 idx_we_first,
  output logic                 idx_we_last,
  output logic [BLK_W-1:0]     idx_waddr,
  output rrl_pkg::span_t       idx_wdata,
  output logic                 idx_re,
  output logic [BLK_W-1:0]     idx_raddr,
  input  rrl_pkg::span_t       idx_rdata
);
  import rrl_pkg::*;

  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int BCNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int OFF_W  = $clog2(BLOCK_SIZE);
  localparam int TOP_W  = $clog2(MAX_ENTRIES + BLOCK_SIZE + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDX_RD,
    S_IDX_CMP,
    S_ENT_SETUP,
    S_ENT_RD,
    S_ENT_CMP,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [BCNT_W-1:0] blk_r, blk_nxt;
  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hix_r, hix_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  logic [31:0]       qa_r, qa_nxt;
  result_t           res_r, res_nxt;

  logic              accept;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid_calc;
  logic [BCNT_W-1:0] nblocks;
  logic [TOP_W-1:0]  blk_top;
  logic              idx_match, idx_below;
  logic              ent_match, ent_below;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign res_valid     = (state_r == S_DONE);
  assign res           = res_r;

  // Midpoint of the half-open window [lo, hix)
  assign mid_sum  = {1'b0, lo_r} + {1'b0, hix_r} - (CNT_W + 1)'(1);
  assign mid_calc = mid_sum[CNT_W:1];

  // Blocks in use, counting a partly filled last block
  assign nblocks = blk_r + BCNT_W'(off_r != '0);

  // End of the chosen block, before it is clipped to the fill level
  assign blk_top = TOP_W'(lo_r) + TOP_W'(BLOCK_SIZE);

  // Probe compares
  assign idx_match = (qa_r >= idx_rdata.first) && (qa_r <= idx_rdata.last);
  assign idx_below = (qa_r < idx_rdata.first);
  assign ent_match = (qa_r >= ent_rdata.first) && (qa_r <= ent_rdata.last);
  assign ent_below = (qa_r < ent_rdata.first);

  // Memory addresses, and write data straight from the request word
  assign ent_waddr       = count_r[ADDR_W-1:0];
  assign ent_wdata.first = in_chan.range_begin;
  assign ent_wdata.last  = in_chan.range_end;
  assign ent_wdata.region = in_chan.range_region;
  assign idx_waddr       = blk_r[BLK_W-1:0];
  assign idx_wdata.first = in_chan.range_begin;
  assign idx_wdata.last  = in_chan.range_end;
  assign ent_raddr       = mid_calc[ADDR_W-1:0];
  assign idx_raddr       = mid_calc[BLK_W-1:0];

  // Next state and datapath
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    blk_nxt      = blk_r;
    off_nxt      = off_r;
    lo_nxt       = lo_r;
    hix_nxt      = hix_r;
    mid_nxt      = mid_r;
    qa_nxt       = qa_r;
    res_nxt      = res_r;
    ent_we       = 1'b0;
    ent_re       = 1'b0;
    idx_we_first = 1'b0;
    idx_we_last  = 1'b0;
    idx_re       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          qa_nxt    = in_chan.query_address;
          state_nxt = S_DONE;
          case (in_chan.func)
            FUNC_CLEAR: begin
              count_nxt = '0;
              blk_nxt   = '0;
              off_nxt   = '0;
            end
            FUNC_APPEND: begin
              if (count_r == CNT_W'(MAX_ENTRIES)) begin
                res_nxt.status = STATUS_FULL;
              end else begin
                // store the range and stretch the current block's span
                ent_we       = 1'b1;
                idx_we_first = (off_r == '0);
                idx_we_last  = 1'b1;
                count_nxt    = count_r + CNT_W'(1);
                if (off_r == OFF_W'(BLOCK_SIZE - 1)) begin
                  off_nxt = '0;
                  blk_nxt = blk_r + BCNT_W'(1);
                end else begin
                  off_nxt = off_r + OFF_W'(1);
                end
              end
            end
            FUNC_LOOKUP: begin
              if (count_r != '0) begin
                lo_nxt    = '0;
                hix_nxt   = CNT_W'(nblocks);
                state_nxt = S_IDX_RD;
              end
            end
            default: ;
          endcase
        end
      end

      S_IDX_RD: begin
        if (lo_r == hix_r) begin
          state_nxt = S_DONE;
        end else begin
          idx_re    = 1'b1;
          mid_nxt   = mid_calc[ADDR_W-1:0];
          state_nxt = S_IDX_CMP;
        end
      end

      S_IDX_CMP: begin
        if (idx_match) begin
          lo_nxt    = CNT_W'(mid_r) * CNT_W'(BLOCK_SIZE);
          state_nxt = S_ENT_SETUP;
        end else if (idx_below) begin
          hix_nxt   = CNT_W'(mid_r);
          state_nxt = S_IDX_RD;
        end else begin
          lo_nxt    = CNT_W'(mid_r) + CNT_W'(1);
          state_nxt = S_IDX_RD;
        end
      end

      S_ENT_SETUP: begin
        if (blk_top > TOP_W'(count_r)) begin
          hix_nxt = count_r;
        end else begin
          hix_nxt = blk_top[CNT_W-1:0];
        end
        state_nxt = S_ENT_RD;
      end

      S_ENT_RD: begin
        if (lo_r == hix_r) begin
          state_nxt = S_DONE;
        end else begin
          ent_re    = 1'b1;
          mid_nxt   = mid_calc[ADDR_W-1:0];
          state_nxt = S_ENT_CMP;
        end
      end

      S_ENT_CMP: begin
        if (ent_match) begin
          res_nxt.region_code = ent_rdata.region;
          res_nxt.hit         = 1'b1;
          state_nxt           = S_DONE;
        end else if (ent_below) begin
          hix_nxt   = CNT_W'(mid_r);
          state_nxt = S_ENT_RD;
        end else begin
          lo_nxt    = CNT_W'(mid_r) + CNT_W'(1);
          state_nxt = S_ENT_RD;
        end
      end

      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, fill level and search registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      blk_r   <= '0;
      off_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      blk_r   <= blk_nxt;
      off_r   <= off_nxt;
    end
    lo_r  <= lo_nxt;
    hix_r <= hix_nxt;
    mid_r <= mid_nxt;
    qa_r  <= qa_nxt;
    res_r <= res_nxt;
  end

endmodule

// File: design/ip_range_region_lookup.sv
`timescale 1ns / 1ps
// Top level of the IP range region lookup: sequencer, memories, result register.
//
// Ranges are appended into a table of MAX_ENTRIES words; the user must append them
// in ascending order, which the block does not check. Every BLOCK_SIZE entries form
// a block whose overall span is kept in a coarse index. One request word is handled
// at a time. Clear, append and unused codes go straight to the result register;
// the word moves on to the output register, and the input is freed, in the same
// cycle, once the output register can take it. A lookup binary-searches the index
// and then the chosen block; each probe is one registered memory read plus a
// compare. The output register lets the next word be accepted while a result
// waits. The memories are not cleared after reset; the fill count alone decides
// which entries take part in a search.
module ip_range_region_lookup #(
  parameter int MAX_ENTRIES = rrl_pkg::MAX_ENTRIES_DEF,
  parameter int BLOCK_SIZE  = rrl_pkg::BLOCK_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rrl_in_if.sink    in_chan,
  rrl_out_if.source out_chan
);
  import rrl_pkg::*;

  localparam int ADDR_W     = $clog2(MAX_ENTRIES);
  localparam int NUM_BLOCKS = (MAX_ENTRIES + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int BLK_W      = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

  logic              res_valid;
  logic              res_ready;
  result_t           res;
  logic              ent_we;
  logic [ADDR_W-1:0] ent_waddr;
  entry_t            ent_wdata;
  logic              ent_re;
  logic [ADDR_W-1:0] ent_raddr;
  entry_t            ent_rdata;
  logic              idx_we_first;
  logic              idx_we_last;
  logic [BLK_W-1:0]  idx_waddr;
  span_t             idx_wdata;
  logic              idx_re;
  logic [BLK_W-1:0]  idx_raddr;
  span_t             idx_rdata;

  logic              out_valid_r;
  result_t           out_word_r;

  rrl_ctrl #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .BLOCK_SIZE  (BLOCK_SIZE)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .ent_we       (ent_we),
    .ent_waddr    (ent_waddr),
    .ent_wdata    (ent_wdata),
    .ent_re       (ent_re),
    .ent_raddr    (ent_raddr),
    .ent_rdata    (ent_rdata),
    .idx_we_first (idx_we_first),
    .idx_we_last  (idx_we_last),
    .idx_waddr    (idx_waddr),
    .idx_wdata    (idx_wdata),
    .idx_re       (idx_re),
    .idx_raddr    (idx_raddr),
    .idx_rdata    (idx_rdata)
  );

  rrl_store #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .BLOCK_SIZE  (BLOCK_SIZE)
  ) u_store (
    .clk          (clk),
    .ent_we       (ent_we),
    .ent_waddr    (ent_waddr),
    .ent_wdata    (ent_wdata),
    .ent_re       (ent_re),
    .ent_raddr    (ent_raddr),
    .ent_rdata    (ent_rdata),
    .idx_we_first (idx_we_first),
    .idx_we_last  (idx_we_last),
    .idx_waddr    (idx_waddr),
    .idx_wdata    (idx_wdata),
    .idx_re       (idx_re),
    .idx_raddr    (idx_raddr),
    .idx_rdata    (idx_rdata)
  );

  // Take a finished word when the output slot is empty or being drained
  assign res_ready = !out_valid_r || out_chan.ready;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_ready && res_valid) begin
      out_word_r <= res;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.region_code = out_word_r.region_code;
  assign out_chan.hit         = out_word_r.hit;
  assign out_chan.status      = out_word_r.status;

  // One word in flight: no second word right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("request accepted while another is in progress");

  // A dropped append never reports a hit
  a_full_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (out_chan.status == STATUS_FULL) |-> !out_chan.hit)
    else $error("full status together with hit");

  // A miss carries region zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.hit |-> (out_chan.region_code == '0))
    else $error("nonzero region on a miss");

endmodule

// File: verif/tb_ip_range_region_lookup.sv
`timescale 1ns / 1ps
// Self-checking testbench: random range tables and lookups checked against an in-bench table model.
module tb_ip_range_region_lookup;
  import rrl_pkg::*;

  localparam int TBL_DEPTH = MAX_ENTRIES_DEF;
  localparam int BLK       = BLOCK_SIZE_DEF;
  localparam int NUM_BLK   = (TBL_DEPTH + BLK - 1) / BLK;
  // Code with no operation behind it
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int RAND_ITEMS = 420;
  localparam int LONG_HOLD  = 300;
  localparam int END_WAIT   = 64;
  // About 850 words, each with its idle gap, busy time and output stall, plus two
  // long holds, taken several times over
  localparam int CYCLE_LIMIT = 400_000;
  localparam int MAX_REPORTS = 200;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] range_begin;
    logic [31:0] range_end;
    logic [31:0] range_region;
    logic [31:0] query_address;
    bit          after_drain;
  } table_req_t;

  logic clk;
  logic rst_n;

  rrl_in_if  req_bus ();
  rrl_out_if resp_bus ();

  ip_range_region_lookup #(
    .MAX_ENTRIES(TBL_DEPTH),
    .BLOCK_SIZE (BLK)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (req_bus),
    .out_chan(resp_bus)
  );

  // Request words still to send and answers still to arrive
  table_req_t requests_todo[$];
  result_t    answers_due[$];
  table_req_t cur_req;

  // Table model
  logic [31:0] tbl_first [TBL_DEPTH];
  logic [31:0] tbl_last  [TBL_DEPTH];
  logic [31:0] tbl_region[TBL_DEPTH];
  logic [31:0] span_first[NUM_BLK];
  logic [31:0] span_last [NUM_BLK];
  int          fill_count = 0;

  // Ranges of the current load, used to aim lookups
  logic [31:0] loaded_first[$];
  logic [31:0] loaded_last[$];

  int reqs_sent    = 0;
  int lookups_sent = 0;
  int results_done = 0;
  int hits_seen    = 0;
  int drops_seen   = 0;
  int errors       = 0;
  int cycles       = 0;
  int tx_idle      = 0;
  int rx_idle      = 0;
  bit tx_steady    = 1'b0;
  bit rx_steady    = 1'b0;

  // Clock and known input levels from time zero
  initial begin
    clk = 1'b0;
    req_bus.valid         = 1'b0;
    req_bus.func          = FUNC_CLEAR;
    req_bus.range_begin   = '0;
    req_bus.range_end     = '0;
    req_bus.range_region  = '0;
    req_bus.query_address = '0;
    resp_bus.ready        = 1'b0;
    forever #5 clk = ~clk;
  end

  // Binary search over index spans (coarse) or table entries; -1 when nothing holds addr
  function automatic int probe_spans(input bit coarse, input int lo_in, input int hi_in,
                                     input logic [31:0] addr);
    int lo, hi, mid;
    logic [31:0] f, l;
    lo = lo_in;
    hi = hi_in;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      f = coarse ? span_first[mid] : tbl_first[mid];
      l = coarse ? span_last[mid]  : tbl_last[mid];
      if (addr >= f && addr <= l) return mid;
      if (addr < f) hi = mid - 1;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  // Apply one request word to the table model and return the answer it gives
  function automatic result_t compute_answer(input table_req_t r);
    result_t ans;
    int n, nblk, blk, base, top, pos;
    ans.region_code = '0;
    ans.hit         = 1'b0;
    ans.status      = STATUS_OK;
    case (r.func)
      FUNC_CLEAR: fill_count = 0;
      FUNC_APPEND: begin
        if (fill_count >= TBL_DEPTH) begin
          ans.status = STATUS_FULL;
        end else begin
          n = fill_count;
          tbl_first[n]  = r.range_begin;
          tbl_last[n]   = r.range_end;
          tbl_region[n] = r.range_region;
          if (n % BLK == 0) span_first[n / BLK] = r.range_begin;
          span_last[n / BLK] = r.range_end;
          fill_count = n + 1;
        end
      end
      FUNC_LOOKUP: begin
        if (fill_count > 0) begin
          nblk = (fill_count + BLK - 1) / BLK;
          blk  = probe_spans(1'b1, 0, nblk - 1, r.query_address);
          if (blk >= 0) begin
            base = blk * BLK;
            top  = base + BLK;
            if (top > fill_count) top = fill_count;
            pos = probe_spans(1'b0, base, top - 1, r.query_address);
            if (pos >= 0) begin
              ans.region_code = tbl_region[pos];
              ans.hit         = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  task automatic push_req(input logic [1:0] f, input logic [31:0] b, input logic [31:0] e,
                          input logic [31:0] r, input logic [31:0] a, input bit drain);
    table_req_t q;
    q.func          = f;
    q.range_begin   = b;
    q.range_end     = e;
    q.range_region  = r;
    q.query_address = a;
    q.after_drain   = drain;
    requests_todo.insert(requests_todo.size(), q);
  endtask

  // Queue n ascending ranges spread over the whole address space
  task automatic load_ranges(input int n);
    logic [63:0] stride, base, b, e;
    logic [31:0] region;
    int i;
    loaded_first.delete();
    loaded_last.delete();
    stride = (n > 0) ? 64'h1_0000_0000 / 64'(n) : 64'h0;
    for (i = 0; i < n; i++) begin
      base = stride * 64'(i);
      b = base + 64'($urandom_range(0, 32'(stride / 4)));
      case ($urandom_range(0, 19))
        0:       e = b;
        1:       e = (b > 0) ? b - 1 : b;
        2:       e = base + stride - 1;
        default: e = b + 64'($urandom_range(0, 32'(stride / 2)));
      endcase
      if (i == 0 && $urandom_range(0, 3) == 0) b = '0;
      if (i == n - 1 && $urandom_range(0, 3) == 0) e = 64'hFFFF_FFFF;
      region = ($urandom_range(0, 15) == 0) ? 32'h0 : $urandom;
      push_req(FUNC_APPEND, b[31:0], e[31:0], region, $urandom, 1'b0);
      loaded_first.insert(loaded_first.size(), b[31:0]);
      loaded_last.insert(loaded_last.size(), e[31:0]);
    end
  endtask

  // Mostly lookups aimed at loaded ranges and their edges; some unused codes and stray appends
  task automatic add_probe_or_noise();
    int pick, k;
    logic [31:0] f, l, addr, b;
    pick = $urandom_range(0, 99);
    if (pick < 5) begin
      push_req(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom, 1'b0);
    end else if (pick < 9) begin
      b = $urandom;
      push_req(FUNC_APPEND, b, b + $urandom_range(0, 32'h00FF_FFFF), $urandom, $urandom, 1'b0);
    end else begin
      addr = $urandom;
      if (loaded_first.size() != 0 && pick >= 25) begin
        k = $urandom_range(0, loaded_first.size() - 1);
        f = loaded_first[k];
        l = loaded_last[k];
        case ($urandom_range(0, 5))
          0:       addr = f;
          1:       addr = l;
          2:       addr = f - 1;
          3:       addr = l + 1;
          default: addr = (l >= f) ? f + $urandom_range(0, l - f) : f;
        endcase
      end
      push_req(FUNC_LOOKUP, $urandom, $urandom, $urandom, addr, 1'b0);
    end
  endtask

  // Clear after draining, load a table of random size, then probe it; stay near the budget
  task automatic build_random_phase(input int budget);
    int pick, n;
    pick = $urandom_range(0, 99);
    if (pick < 10) n = $urandom_range(0, 2);
    else if (pick < 22 && budget > BLK + 200) n = $urandom_range(BLK + 1, BLK + 144);
    else n = $urandom_range(3, 40);
    push_req(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b1);
    load_ranges(n);
    repeat ($urandom_range(10, 40)) add_probe_or_noise();
  endtask

  // Stimulus, reset and end of run
  initial begin
    int rand_base;
    rst_n = 1'b0;

    // Empty table, unused codes with extreme fields
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'h0000_0000, 1'b0);
    push_req(FUNC_LOOKUP, '1, '1, '1, 32'hFFFF_FFFF, 1'b0);
    push_req(FUNC_UNUSED, '1, '1, '1, '1, 1'b0);
    push_req(FUNC_UNUSED, '0, '0, '0, '0, 1'b0);
    // Ranges at both ends of the space, a zero region and one with end below begin
    push_req(FUNC_APPEND, 32'h0000_0000, 32'h0000_FFFF, 32'hFFFF_FFFF, '0, 1'b0);
    push_req(FUNC_APPEND, 32'h0001_0000, 32'h0001_FFFF, 32'h0000_0000, '1, 1'b0);
    push_req(FUNC_APPEND, 32'h8000_0005, 32'h8000_0000, 32'h1234_5678, '0, 1'b0);
    push_req(FUNC_APPEND, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hA5A5_A5A5, '0, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'h0000_0000, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'h0000_FFFF, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'h0001_8000, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'h8000_0002, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'h7FFF_FFFF, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'hFFFF_FFFF, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'hFFFF_FEFF, 1'b0);
    push_req(FUNC_UNUSED, $urandom, $urandom, $urandom, $urandom, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'h0000_0010, 1'b0);
    // Clear, then an unordered, overlapping pair
    push_req(FUNC_CLEAR, '1, '1, '1, '1, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'h0000_0000, 1'b0);
    push_req(FUNC_APPEND, 32'h5000_0000, 32'h6FFF_FFFF, 32'h0000_0011, '0, 1'b0);
    push_req(FUNC_APPEND, 32'h1000_0000, 32'h5FFF_FFFF, 32'h0000_0022, '0, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'h5800_0000, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'h2000_0000, 1'b0);

    // One table that fills a block and may reach into the next, probed hard
    push_req(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b1);
    load_ranges($urandom_range(BLK, BLK + 63));
    repeat (40) add_probe_or_noise();

    rand_base = requests_todo.size();
    while (requests_todo.size() - rand_base < RAND_ITEMS)
      build_random_phase(RAND_ITEMS - (requests_todo.size() - rand_base));

    // Reuse the table after a clear
    push_req(FUNC_CLEAR, $urandom, $urandom, $urandom, $urandom, 1'b0);
    push_req(FUNC_APPEND, 32'h0A00_0000, 32'h0AFF_FFFF, 32'h0000_0A0A, '0, 1'b0);
    push_req(FUNC_LOOKUP, '0, '0, '0, 32'h0A12_3456, 1'b0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every word is sent and answered, then let the block settle
    while (requests_todo.size() != 0 || req_bus.valid || reqs_sent != results_done)
      @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    $display("Checked %0d results for %0d request words: %0d lookups, %0d hits, %0d drops",
             results_done, reqs_sent, lookups_sent, hits_seen, drops_seen);
    $display("Tables from empty to past one block of %0d, unordered loads included.",
             BLK);
    if (errors == 0) begin
      $display("ip_range_region_lookup test passed");
    end else begin
      $display("ip_range_region_lookup test failed");
    end
    $finish;
  end

  // Request driver: predict on acceptance, then offer the next word after a random gap
  always @(posedge clk) begin : drive_requests
    bit took, drained, offer;
    int gap;
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
      tx_idle <= 0;
    end else begin
      took    = req_bus.valid && req_bus.ready;
      // Answers already in plus one arriving at this edge cover every word sent
      drained = !took && (reqs_sent == results_done + (resp_bus.valid && resp_bus.ready));
      offer   = req_bus.valid && !took;
      gap     = tx_idle;
      if (took) begin
        answers_due.insert(answers_due.size(), compute_answer(cur_req));
        reqs_sent++;
        if (cur_req.func == FUNC_LOOKUP) lookups_sent++;
        if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
        gap = tx_steady ? 0 : $urandom_range(0, 14);
      end
      if (!offer) begin
        if (gap > 0) begin
          tx_idle <= gap - 1;
        end else if (requests_todo.size() != 0 &&
                     (!requests_todo[0].after_drain || drained)) begin
          cur_req = requests_todo.pop_front();
          req_bus.func          <= cur_req.func;
          req_bus.range_begin   <= cur_req.range_begin;
          req_bus.range_end     <= cur_req.range_end;
          req_bus.range_region  <= cur_req.range_region;
          req_bus.query_address <= cur_req.query_address;
          offer = 1'b1;
        end
      end
      req_bus.valid <= offer;
    end
  end

  // Result monitor: compare each word with the oldest answer, then stall at random
  always @(posedge clk) begin : check_results
    result_t want;
    int stall;
    if (!rst_n) begin
      resp_bus.ready <= 1'b0;
      rx_idle <= 0;
    end else begin
      stall = rx_idle;
      if (resp_bus.valid && resp_bus.ready) begin
        if (answers_due.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("%0t: result with no answer due: expected none, actual %h/%b/%b",
                     $time, resp_bus.region_code, resp_bus.hit, resp_bus.status);
        end else begin
          want = answers_due.pop_front();
          if (resp_bus.region_code !== want.region_code) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: region_code mismatch: expected %h, actual %h",
                       $time, want.region_code, resp_bus.region_code);
          end
          if (resp_bus.hit !== want.hit) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: hit mismatch: expected %b, actual %b",
                       $time, want.hit, resp_bus.hit);
          end
          if (resp_bus.status !== want.status) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: status mismatch: expected %b, actual %b",
                       $time, want.status, resp_bus.status);
          end
        end
        if (resp_bus.hit === 1'b1) hits_seen++;
        if (resp_bus.status === STATUS_FULL) drops_seen++;
        results_done <= results_done + 1;
        // Hold off long twice so the block backs up into its input
        if (results_done == 60 || results_done == 700) begin
          stall = LONG_HOLD;
        end else begin
          if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
          stall = rx_steady ? 0 : $urandom_range(0, 14);
        end
      end
      if (stall > 0) begin
        resp_bus.ready <= 1'b0;
        rx_idle <= stall - 1;
      end else begin
        resp_bus.ready <= 1'b1;
        rx_idle <= 0;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: no progress after %0d cycles, %0d answers still due",
               $time, cycles, answers_due.size());
      $display("ip_range_region_lookup test failed");
      $finish;
    end
  end

endmodule
